// File: rtl/core/npcs_pkg.sv
// Package for the nearest palette color search core.
// Holds the palette size, command codes and the item type for front, back and top.
// No dependencies.
package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W = ADDR_W + 1;
    localparam int DIST_W = 18;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic       command;
        logic       wr_ok;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_item;

endpackage

// File: rtl/core/npcs_front.sv
// Front part of the nearest palette color search core.
// Accepts items, flags writes whose index lies in the palette, and queues them.
// Depends on npcs_pkg.
module npcs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic           i_command,
    input  logic [7:0]     i_entry_index,
    input  logic [7:0]     i_red,
    input  logic [7:0]     i_green,
    input  logic [7:0]     i_blue,
    output npcs_pkg::t_item o_head,
    output logic           o_head_vld,
    input  logic           i_take
);

    npcs_pkg::t_item r_slots [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    npcs_pkg::t_item w_item;
    logic            w_push_ok;
    logic            w_take_ok;

    always_comb begin
        w_item.command     = i_command;
        w_item.wr_ok       = ({1'b0, i_entry_index} < 9'(npcs_pkg::PALETTE_ENTRIES));
        w_item.entry_index = i_entry_index;
        w_item.red         = i_red;
        w_item.green       = i_green;
        w_item.blue        = i_blue;
    end

    assign o_full     = (r_count == 2'd2);
    assign o_head_vld = (r_count != 2'd0);
    assign o_head     = r_slots[r_rd_ptr];
    assign w_push_ok  = i_push && !o_full;
    assign w_take_ok  = i_take && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slots[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_take_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push_ok && !w_take_ok) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push_ok && w_take_ok) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/npcs_back.sv
// Back part of the nearest palette color search core.
// Holds the palette memory, runs the pipelined search and the result register.
// Depends on npcs_pkg.
module npcs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  npcs_pkg::t_item i_head,
    input  logic            i_head_vld,
    output logic            o_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [7:0]      o_best_index
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;

    localparam int N = npcs_pkg::PALETTE_ENTRIES;
    localparam int AW = npcs_pkg::ADDR_W;
    localparam int CW = npcs_pkg::CNT_W;
    localparam int DW = npcs_pkg::DIST_W;

    logic [23:0]   r_mem [N];
    logic [N-1:0]  r_ent_vld;

    logic [1:0]    r_state;
    logic [CW-1:0] r_addr;
    logic [7:0]    r_qr;
    logic [7:0]    r_qg;
    logic [7:0]    r_qb;

    logic [23:0]   r_rd_data;
    logic          r_rd_ent;
    logic          r_rd_vld;
    logic          r_rd_last;
    logic [7:0]    r_rd_idx;

    logic [15:0]   r_sq_r;
    logic [15:0]   r_sq_g;
    logic [15:0]   r_sq_b;
    logic          r_sq_vld;
    logic          r_sq_last;
    logic [7:0]    r_sq_idx;

    logic [DW-1:0] r_best_dist;
    logic [7:0]    r_best;
    logic          r_out_vld;
    logic [7:0]    r_out_idx;

    logic          w_start_wr;
    logic          w_start_q;
    logic          w_issue;
    logic          w_issue_last;
    logic [23:0]   w_ent;
    logic [7:0]    w_dr;
    logic [7:0]    w_dg;
    logic [7:0]    w_db;
    logic [DW-1:0] w_dist;
    logic          w_better;
    logic [7:0]    n_best;
    logic [DW-1:0] n_best_dist;

    assign w_start_wr = i_head_vld && (r_state == S_IDLE)
                        && (i_head.command == npcs_pkg::CMD_WRITE);
    assign w_start_q  = i_head_vld && (r_state == S_IDLE) && !r_out_vld
                        && (i_head.command == npcs_pkg::CMD_QUERY);
    assign o_take     = w_start_wr || w_start_q;
    assign w_issue    = (r_state == S_SEARCH);
    assign w_issue_last = (r_addr == CW'(N - 1));

    always_ff @(posedge i_clk) begin
        if (w_start_wr && i_head.wr_ok) begin
            r_mem[i_head.entry_index[AW-1:0]] <= {i_head.red, i_head.green, i_head.blue};
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
            r_rd_ent  <= r_ent_vld[r_addr[AW-1:0]];
        end
        r_rd_last <= w_issue_last;
        r_rd_idx  <= 8'(r_addr);
    end

    assign w_ent = r_rd_ent ? r_rd_data : 24'd0;
    assign w_dr  = (r_qr >= w_ent[23:16]) ? (r_qr - w_ent[23:16]) : (w_ent[23:16] - r_qr);
    assign w_dg  = (r_qg >= w_ent[15:8])  ? (r_qg - w_ent[15:8])  : (w_ent[15:8] - r_qg);
    assign w_db  = (r_qb >= w_ent[7:0])   ? (r_qb - w_ent[7:0])   : (w_ent[7:0] - r_qb);

    always_ff @(posedge i_clk) begin
        r_sq_r    <= 16'(w_dr) * 16'(w_dr);
        r_sq_g    <= 16'(w_dg) * 16'(w_dg);
        r_sq_b    <= 16'(w_db) * 16'(w_db);
        r_sq_last <= r_rd_last;
        r_sq_idx  <= r_rd_idx;
    end

    assign w_dist      = DW'(r_sq_r) + DW'(r_sq_g) + DW'(r_sq_b);
    assign w_better    = (w_dist < r_best_dist);
    assign n_best      = w_better ? r_sq_idx : r_best;
    assign n_best_dist = w_better ? w_dist : r_best_dist;

    always_ff @(posedge i_clk) begin
        if (w_start_q) begin
            r_qr <= i_head.red;
            r_qg <= i_head.green;
            r_qb <= i_head.blue;
        end
        if (w_start_q) begin
            r_best_dist <= '1;
            r_best      <= 8'd0;
        end else if (r_sq_vld) begin
            r_best_dist <= n_best_dist;
            r_best      <= n_best;
        end
        if (r_sq_vld && r_sq_last) begin
            r_out_idx <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_sq_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            r_sq_vld <= r_rd_vld;
            if (w_start_wr && i_head.wr_ok) begin
                r_ent_vld[i_head.entry_index[AW-1:0]] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start_q) begin
                        r_addr  <= '0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_addr <= r_addr + CW'(1);
                    if (w_issue_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_sq_vld && r_sq_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_sq_vld && r_sq_last) begin
                r_out_vld <= 1'b1;
            end else if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_out_vld;
    assign o_best_index = r_out_idx;

endmodule

// File: rtl/core/nearest_palette_color_search_core.sv
// Top level of the nearest palette color search core.
// Joins the input queue front and the palette search back; depends on npcs_pkg,
// npcs_front and npcs_back.
//
// A write item stores a color at one palette entry and gives no result; a
// query item returns the index of the entry with the smallest squared
// Euclidean distance to its color, the lowest index on ties. The palette
// reads as all zero after reset, with no clearing pass. A query scans
// every one of the PALETTE_ENTRIES entries through the single palette
// memory port, one entry per cycle; the next query starts only after the
// previous result has been popped. Up to two items wait in the front
// queue while the back part is busy.
module nearest_palette_color_search_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_command,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_best_index
);

    npcs_pkg::t_item w_head;
    logic            w_head_vld;
    logic            w_take;

    npcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_head        (w_head),
        .o_head_vld    (w_head_vld),
        .i_take        (w_take)
    );

    npcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_vld   (w_head_vld),
        .o_take       (w_take),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_best_index (o_best_index)
    );

endmodule

// File: rtl/core/npcs_checker.sv
// Port-level checker for the nearest palette color search core.
// Bound to the top level; depends only on its ports.
module npcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_full,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_best_index
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("Result queue is not empty after reset.");

    a_room_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_full)
        else $error("Input queue is full after reset.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_best_index)))
        else $error("Waiting result changed before it was popped.");

    a_no_instant_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop) |=> o_empty)
        else $error("A new result appeared right after a pop.");

endmodule

bind nearest_palette_color_search_core npcs_checker u_npcs_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for the nearest palette color search core: palette writes and queries
// checked against a scoreboard that mirrors the palette. Depends on npcs_pkg and
// nearest_palette_color_search_core.
module testbench;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int RANDOM_ITEMS = 1580;

    class palette_scoreboard;
        logic [23:0] palette [npcs_pkg::PALETTE_ENTRIES];
        logic [7:0]  expected_index [$];
        int          errors;

        function new();
            foreach (palette[i]) palette[i] = '0;
            errors = 0;
        endfunction

        function logic [7:0] nearest_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int i, dr, dg, db, sq_dist, best_dist;
            logic [7:0] best;
            best = '0;
            best_dist = 32'h7fffffff;
            for (i = 0; i < npcs_pkg::PALETTE_ENTRIES; i++) begin
                dr = int'(r) - int'(palette[i][23:16]);
                dg = int'(g) - int'(palette[i][15:8]);
                db = int'(b) - int'(palette[i][7:0]);
                sq_dist = dr * dr + dg * dg + db * db;
                if (sq_dist < best_dist) begin
                    best = i[7:0];
                    best_dist = sq_dist;
                end
            end
            return best;
        endfunction

        function void note_item(logic cmd, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b);
            if (cmd == npcs_pkg::CMD_WRITE) begin
                if (int'(idx) < npcs_pkg::PALETTE_ENTRIES) palette[idx] = {r, g, b};
            end else begin
                expected_index.push_back(nearest_entry(r, g, b));
            end
        endfunction

        function void check_index(logic [7:0] actual);
            logic [7:0] want;
            if (expected_index.size() == 0) begin
                $error("best_index: no result expected, actual %0d", actual);
                errors++;
            end else begin
                want = expected_index.pop_front();
                if (actual !== want) begin
                    $error("best_index mismatch: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic       o_full;
    logic       i_command = npcs_pkg::CMD_WRITE;
    logic [7:0] i_entry_index = '0;
    logic [7:0] i_red = '0;
    logic [7:0] i_green = '0;
    logic [7:0] i_blue = '0;
    logic       o_empty;
    logic       i_pop = 1'b0;
    logic [7:0] o_best_index;

    palette_scoreboard sb = new();
    int accepted_items = 0;

    nearest_palette_color_search_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(i_push),
        .o_full(o_full),
        .i_command(i_command),
        .i_entry_index(i_entry_index),
        .i_red(i_red),
        .i_green(i_green),
        .i_blue(i_blue),
        .o_empty(o_empty),
        .i_pop(i_pop),
        .o_best_index(o_best_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                sb.note_item(i_command, i_entry_index, i_red, i_green, i_blue);
                accepted_items++;
            end
            if (i_pop && !o_empty) sb.check_index(o_best_index);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver holds off once for a long stretch so that the core fills up.
    initial begin
        int mode, span, k;
        bit held_off;
        held_off = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && accepted_items >= 300) begin
                held_off = 1'b1;
                i_pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (k = 0; k < span; k++) begin
                case (mode)
                    0: i_pop <= 1'b1;
                    1: i_pop <= 1'($urandom_range(0, 1));
                    2: i_pop <= ($urandom_range(0, 9) == 0);
                    default: i_pop <= (k % 4 == 3);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        i_push <= 1'b1;
        i_command <= cmd;
        i_entry_index <= idx;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (o_full);
    endtask

    task automatic send_random_items(input int count);
        int n, kind, burst_left;
        logic [7:0] idx, r, g, b;
        logic [23:0] base;
        burst_left = $urandom_range(1, 40);
        for (n = 0; n < count; n++) begin
            idx = 8'($urandom);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            base = sb.palette[8'($urandom_range(0, npcs_pkg::PALETTE_ENTRIES - 1))];
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                send_item(npcs_pkg::CMD_WRITE, 8'($urandom_range(0, 15)), r, g, b);
            end else if (kind < 25) begin
                send_item(npcs_pkg::CMD_WRITE, idx, base[23:16], base[15:8], base[7:0]);
            end else if (kind < 40) begin
                send_item(npcs_pkg::CMD_WRITE, idx, r, g, b);
            end else if (kind < 60) begin
                send_item(npcs_pkg::CMD_QUERY, idx, base[23:16], base[15:8], base[7:0]);
            end else if (kind < 75) begin
                send_item(npcs_pkg::CMD_QUERY, idx,
                          base[23:16] + 8'($urandom_range(0, 6)) - 8'd3,
                          base[15:8] + 8'($urandom_range(0, 6)) - 8'd3,
                          base[7:0] + 8'($urandom_range(0, 6)) - 8'd3);
            end else if (kind < 85) begin
                send_item(npcs_pkg::CMD_QUERY, idx, {8{r[0]}}, {8{g[0]}}, {8{b[0]}});
            end else begin
                send_item(npcs_pkg::CMD_QUERY, idx, r, g, b);
            end
            burst_left--;
            if (burst_left == 0) begin
                i_push <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(npcs_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(npcs_pkg::CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(npcs_pkg::CMD_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_item(npcs_pkg::CMD_QUERY, 8'h12, 8'h80, 8'h80, 8'h80);
        send_item(npcs_pkg::CMD_WRITE, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_item(npcs_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::CMD_WRITE, 8'd10, 8'd100, 8'd0, 8'd0);
        send_item(npcs_pkg::CMD_WRITE, 8'd20, 8'd140, 8'd0, 8'd0);
        send_item(npcs_pkg::CMD_QUERY, 8'd20, 8'd120, 8'd0, 8'd0);
        send_item(npcs_pkg::CMD_WRITE, 8'd5, 8'd7, 8'd8, 8'd9);
        send_item(npcs_pkg::CMD_WRITE, 8'd6, 8'd7, 8'd8, 8'd9);
        send_item(npcs_pkg::CMD_QUERY, 8'd6, 8'd7, 8'd8, 8'd9);
        send_item(npcs_pkg::CMD_WRITE, 8'h80, 8'h55, 8'hAA, 8'h55);
        send_item(npcs_pkg::CMD_QUERY, 8'hAB, 8'hAA, 8'h55, 8'hAA);
        send_item(npcs_pkg::CMD_QUERY, 8'h54, 8'h55, 8'hAA, 8'h55);
        send_item(npcs_pkg::CMD_WRITE, 8'h01, 8'hFF, 8'hFF, 8'hFF);
        send_item(npcs_pkg::CMD_QUERY, 8'hFF, 8'hFA, 8'hFA, 8'hFA);
        send_item(npcs_pkg::CMD_WRITE, 8'h7F, 8'h00, 8'hFF, 8'h00);
        send_item(npcs_pkg::CMD_QUERY, 8'h7F, 8'h00, 8'hFF, 8'h00);

        send_random_items(RANDOM_ITEMS);
        i_push <= 1'b0;

        while (sb.expected_index.size() != 0) @(posedge i_clk);
        repeat (npcs_pkg::PALETTE_ENTRIES + 16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
